// ===== rtl/esqd_pkg.sv =====
// ----------------------------------------------------------------------------
// esqd_pkg
// Shared types, tag codes and lookup tables for the extended squitter decoder.
// ----------------------------------------------------------------------------
package esqd_pkg;

  localparam int MSG_W       = 56;
  localparam int TAIL_W      = 32;
  localparam int BITS_W      = MSG_W + TAIL_W;
  localparam int NUM_TAGS    = 23;
  localparam int TAG_W       = 5;
  localparam int VALUE_W     = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [TAG_W-1:0] TAG_VALID     = 5'd0;
  localparam logic [TAG_W-1:0] TAG_FORMAT    = 5'd1;
  localparam logic [TAG_W-1:0] TAG_ADDRESS   = 5'd2;
  localparam logic [TAG_W-1:0] TAG_TYPECODE  = 5'd3;
  localparam logic [TAG_W-1:0] TAG_CATEGORY  = 5'd4;
  localparam logic [TAG_W-1:0] TAG_CHAR      = 5'd5;
  localparam logic [TAG_W-1:0] TAG_SURV      = 5'd6;
  localparam logic [TAG_W-1:0] TAG_SAF       = 5'd7;
  localparam logic [TAG_W-1:0] TAG_ALTITUDE  = 5'd8;
  localparam logic [TAG_W-1:0] TAG_GNSS_ALT  = 5'd9;
  localparam logic [TAG_W-1:0] TAG_TIME      = 5'd10;
  localparam logic [TAG_W-1:0] TAG_CPR_FMT   = 5'd11;
  localparam logic [TAG_W-1:0] TAG_CPR_LAT   = 5'd12;
  localparam logic [TAG_W-1:0] TAG_CPR_LON   = 5'd13;
  localparam logic [TAG_W-1:0] TAG_VEL_TYPE  = 5'd14;
  localparam logic [TAG_W-1:0] TAG_INTENT    = 5'd15;
  localparam logic [TAG_W-1:0] TAG_IFR       = 5'd16;
  localparam logic [TAG_W-1:0] TAG_NUC       = 5'd17;
  localparam logic [TAG_W-1:0] TAG_EW        = 5'd18;
  localparam logic [TAG_W-1:0] TAG_NS        = 5'd19;
  localparam logic [TAG_W-1:0] TAG_VR_SRC    = 5'd20;
  localparam logic [TAG_W-1:0] TAG_VR        = 5'd21;
  localparam logic [TAG_W-1:0] TAG_ALT_DIFF  = 5'd22;

  localparam logic [3:0] FMT_UNKNOWN = 4'd11;
  localparam logic [5:0] CODE_SPACE  = 6'd32;

  localparam logic [4:0] CAT_CODE [32] = '{
    5'd1, 5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
    5'd1, 5'd2,  5'd1,  5'd3,  5'd4,  5'd4,  5'd4,  5'd4,
    5'd1, 5'd5,  5'd6,  5'd7,  5'd8,  5'd1,  5'd9,  5'd10,
    5'd1, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
  };

  typedef struct packed {
    logic                  valid;
    logic [3:0]            fmt;
    logic [4:0]            tc;
    logic [NUM_TAGS-1:0]   mask;
    logic [2:0]            first;
    logic [2:0]            last;
    logic [BITS_W-1:0]     bits;
  } desc_t;

  function automatic logic [3:0] format_code(input logic [4:0] df);
    logic [3:0] code;
    case (df)
      5'd0:    code = 4'd0;
      5'd4:    code = 4'd1;
      5'd5:    code = 4'd2;
      5'd11:   code = 4'd3;
      5'd16:   code = 4'd4;
      5'd17:   code = 4'd5;
      5'd18:   code = 4'd6;
      5'd19:   code = 4'd7;
      5'd20:   code = 4'd8;
      5'd21:   code = 4'd9;
      5'd24:   code = 4'd10;
      default: code = FMT_UNKNOWN;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] id_char(input logic [5:0] code);
    logic [7:0] ch;
    if (code >= 6'd1 && code <= 6'd26) begin
      ch = 8'd64 + {2'b00, code};
    end else if (code == CODE_SPACE) begin
      ch = 8'd32;
    end else if (code >= 6'd48 && code <= 6'd57) begin
      ch = {2'b00, code};
    end else begin
      ch = 8'd35;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/esqd_front.sv =====
// ----------------------------------------------------------------------------
// esqd_front
// Classifies an incoming request into a descriptor: header values, the set
// of result tags to emit, callsign span and the message bits the back needs.
// ----------------------------------------------------------------------------
module esqd_front (
  input  logic [esqd_pkg::MSG_W-1:0] message_high,
  input  logic [esqd_pkg::MSG_W-1:0] message_low,
  input  logic [3:0]                 byte_count,
  input  logic                       crc_ok,
  output esqd_pkg::desc_t            desc
);
  import esqd_pkg::*;

  logic                 len_ok;
  logic                 valid;
  logic [4:0]           df;
  logic [4:0]           tc_raw;
  logic [4:0]           tc;
  logic                 tc_known;
  logic [2:0]           st;
  logic [MSG_W-1:0]     lo;
  logic [BITS_W-1:0]    m;
  logic [7:0]           nonspace;
  logic [2:0]           first;
  logic [2:0]           last;
  logic [NUM_TAGS-1:0]  mask;

  always_comb begin
    len_ok = (byte_count == 4'd7) || (byte_count == 4'd14);
    valid  = len_ok && crc_ok;
    lo     = (byte_count == 4'd14) ? message_low : '0;
    m      = {message_high, lo[MSG_W-1 -: TAIL_W]};
    df     = message_high[55:51];
    tc_raw = m[55:51];
    st     = m[50:48];
    tc_known = (tc_raw >= 5'd1 && tc_raw <= 5'd22) || tc_raw == 5'd28 ||
               tc_raw == 5'd29 || tc_raw == 5'd31;
    tc = tc_known ? tc_raw : 5'd0;

    for (int i = 0; i < 8; i++) begin
      nonspace[i] = (m[47 - 6*i -: 6] != CODE_SPACE);
    end
    first = '0;
    for (int i = 7; i >= 0; i--) begin
      if (nonspace[i]) first = 3'(i);
    end
    last = '0;
    for (int i = 0; i < 8; i++) begin
      if (nonspace[i]) last = 3'(i);
    end

    mask = '0;
    mask[TAG_VALID]  = 1'b1;
    mask[TAG_FORMAT] = 1'b1;
    if (valid) begin
      mask[TAG_ADDRESS] = 1'b1;
      if (df == 5'd17 || df == 5'd18) begin
        mask[TAG_TYPECODE] = 1'b1;
        if (tc >= 5'd1 && tc <= 5'd4) begin
          mask[TAG_CATEGORY] = 1'b1;
          mask[TAG_CHAR]     = |nonspace;
        end else if ((tc >= 5'd9 && tc <= 5'd18) || (tc >= 5'd20 && tc <= 5'd22)) begin
          mask[TAG_CPR_LON:TAG_SURV] = '1;
        end else if (tc == 5'd19) begin
          mask[TAG_VEL_TYPE] = 1'b1;
          if (st != 3'd0 && st <= 3'd4) begin
            mask[TAG_INTENT]   = 1'b1;
            mask[TAG_IFR]      = 1'b1;
            mask[TAG_NUC]      = 1'b1;
            mask[TAG_EW]       = (st <= 3'd2) && (m[41:32] != '0);
            mask[TAG_NS]       = (st <= 3'd2) && (m[30:21] != '0);
            mask[TAG_VR_SRC]   = 1'b1;
            mask[TAG_VR]       = (m[18:10] != '0);
            mask[TAG_ALT_DIFF] = (m[6:0] != '0);
          end
        end
      end
    end

    desc.valid = valid;
    desc.fmt   = len_ok ? format_code(df) : FMT_UNKNOWN;
    desc.tc    = tc;
    desc.mask  = mask;
    desc.first = first;
    desc.last  = last;
    desc.bits  = m;
  end

endmodule

// ===== rtl/esqd_queue.sv =====
// ----------------------------------------------------------------------------
// esqd_queue
// Short descriptor queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module esqd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esqd_pkg::desc_t push_desc,
  input  logic            pop,
  output esqd_pkg::desc_t head_desc,
  output logic            not_empty,
  output logic            full
);
  import esqd_pkg::*;

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/esqd_back.sv =====
// ----------------------------------------------------------------------------
// esqd_back
// Result sequencer: walks the tag set of one descriptor, one field per cycle,
// and forms each field value into the output register.
// ----------------------------------------------------------------------------
module esqd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  esqd_pkg::desc_t               head_desc,
  input  logic                          head_avail,
  output logic                          pop,
  output logic                          out_strobe,
  output logic [esqd_pkg::TAG_W-1:0]    out_field_tag,
  output logic signed [esqd_pkg::VALUE_W-1:0] out_field_value,
  output logic                          out_last_of_message
);
  import esqd_pkg::*;

  logic                       active_r, active_nxt;
  desc_t                      cur_r, cur_nxt;
  logic [NUM_TAGS-1:0]        mask_r, mask_nxt;
  logic [2:0]                 ci_r, ci_nxt;
  logic                       strobe_r;
  logic [TAG_W-1:0]           tag_r;
  logic signed [VALUE_W-1:0]  value_r;
  logic                       last_r;

  logic [TAG_W-1:0]           tag;
  logic [NUM_TAGS-1:0]        mask_left;
  logic                       done;
  logic signed [VALUE_W-1:0]  value;
  logic [BITS_W-1:0]          m;
  logic [10:0]                alt_n;
  logic signed [VALUE_W-1:0]  ext;
  logic signed [VALUE_W-1:0]  mag;
  logic                       neg;
  logic [2:0]                 st;

  always_comb begin
    m  = cur_r.bits;
    st = m[50:48];

    tag = TAG_VALID;
    for (int i = NUM_TAGS - 1; i >= 0; i--) begin
      if (mask_r[i]) tag = TAG_W'(i);
    end

    mask_left = mask_r;
    if (!(tag == TAG_CHAR && ci_r != cur_r.last)) begin
      mask_left[tag] = 1'b0;
    end
    done = (mask_left == '0);

    alt_n = {m[47:41], m[39:36]};
    ext   = '0;
    neg   = 1'b0;
    case (tag)
      TAG_EW: begin
        ext = VALUE_W'(m[41:32]) - 1'b1;
        neg = m[42];
      end
      TAG_NS: begin
        ext = VALUE_W'(m[30:21]) - 1'b1;
        neg = m[31];
      end
      TAG_VR: begin
        ext = VALUE_W'(m[18:10]) - 1'b1;
        neg = m[19];
      end
      TAG_ALT_DIFF: begin
        ext = VALUE_W'(m[6:0]) - 1'b1;
        neg = m[7];
      end
      default: begin
        ext = VALUE_W'(alt_n);
        neg = 1'b0;
      end
    endcase
    case (tag)
      TAG_EW, TAG_NS: mag = (st == 3'd2) ? (ext <<< 2) : ext;
      TAG_VR:         mag = ext <<< 6;
      default:        mag = ext * 25'sd25;
    endcase

    case (tag)
      TAG_VALID:    value = VALUE_W'(cur_r.valid);
      TAG_FORMAT:   value = VALUE_W'(cur_r.fmt);
      TAG_ADDRESS:  value = VALUE_W'(m[79:56]);
      TAG_TYPECODE: value = VALUE_W'(cur_r.tc);
      TAG_CATEGORY: value = VALUE_W'(CAT_CODE[{cur_r.tc[1:0] - 2'd1, m[50:48]}]);
      TAG_CHAR:     value = VALUE_W'(id_char(m[47 - 6*ci_r -: 6]));
      TAG_SURV:     value = VALUE_W'(m[50:49] != 2'b00);
      TAG_SAF:      value = VALUE_W'(m[48]);
      TAG_ALTITUDE: value = m[40] ? (mag - 25'sd1000) : -25'sd1;
      TAG_GNSS_ALT: value = VALUE_W'(cur_r.tc >= 5'd20 && cur_r.tc <= 5'd22);
      TAG_TIME:     value = VALUE_W'(m[35]);
      TAG_CPR_FMT:  value = VALUE_W'(m[34]);
      TAG_CPR_LAT:  value = VALUE_W'(m[33:17]);
      TAG_CPR_LON:  value = VALUE_W'(m[16:0]);
      TAG_VEL_TYPE: begin
        if (st == 3'd0 || st > 3'd4) begin
          value = '0;
        end else if (st <= 3'd2) begin
          value = 25'sd1;
        end else begin
          value = 25'sd2;
        end
      end
      TAG_INTENT:   value = VALUE_W'(m[47]);
      TAG_IFR:      value = VALUE_W'(m[46]);
      TAG_NUC:      value = VALUE_W'(m[45:43]);
      TAG_VR_SRC:   value = VALUE_W'(m[20]);
      TAG_EW, TAG_NS, TAG_VR, TAG_ALT_DIFF: value = neg ? -mag : mag;
      default:      value = '0;
    endcase

    pop        = head_avail && (!active_r || done);
    active_nxt = active_r;
    cur_nxt    = cur_r;
    mask_nxt   = mask_r;
    ci_nxt     = ci_r;
    if (pop) begin
      active_nxt = 1'b1;
      cur_nxt    = head_desc;
      mask_nxt   = head_desc.mask;
      ci_nxt     = head_desc.first;
    end else if (active_r) begin
      active_nxt = !done;
      mask_nxt   = mask_left;
      if (tag == TAG_CHAR) begin
        ci_nxt = ci_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= active_r;
    end
    cur_r   <= cur_nxt;
    mask_r  <= mask_nxt;
    ci_r    <= ci_nxt;
    tag_r   <= tag;
    value_r <= value;
    last_r  <= done;
  end

  assign out_strobe          = strobe_r;
  assign out_field_tag       = tag_r;
  assign out_field_value     = value_r;
  assign out_last_of_message = last_r;

endmodule

// ===== rtl/extended_squitter_field_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// extended_squitter_field_decoder_unit
// Decodes one Mode S message per request into a stream of tagged fields.
// ----------------------------------------------------------------------------
// channel   ports                                     handshake
// request   in_message_high/low, in_byte_count,       start && !busy
//           in_crc_ok
// result    out_field_tag, out_field_value,           out_strobe, one cycle
//           out_last_of_message
//
// A message yields 2 to 13 results, one per cycle from the result sequencer;
// results of the next queued message follow with no gap between messages.
// A request passes the queue, then the descriptor and output registers.
// Up to four classified requests wait in the queue; busy is high when full.
// Reset clears the queue and sequencer; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module extended_squitter_field_decoder_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [esqd_pkg::MSG_W-1:0]            in_message_high,
  input  logic [esqd_pkg::MSG_W-1:0]            in_message_low,
  input  logic [3:0]                            in_byte_count,
  input  logic                                  in_crc_ok,
  output logic                                  out_strobe,
  output logic [esqd_pkg::TAG_W-1:0]            out_field_tag,
  output logic signed [esqd_pkg::VALUE_W-1:0]   out_field_value,
  output logic                                  out_last_of_message
);
  import esqd_pkg::*;

  desc_t front_desc;
  desc_t head_desc;
  logic  push;
  logic  pop;
  logic  head_avail;
  logic  full;

  assign busy = full;
  assign push = start && !full;

  esqd_front u_front (
    .message_high (in_message_high),
    .message_low  (in_message_low),
    .byte_count   (in_byte_count),
    .crc_ok       (in_crc_ok),
    .desc         (front_desc)
  );

  esqd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (front_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .not_empty (head_avail),
    .full      (full)
  );

  esqd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_desc           (head_desc),
    .head_avail          (head_avail),
    .pop                 (pop),
    .out_strobe          (out_strobe),
    .out_field_tag       (out_field_tag),
    .out_field_value     (out_field_value),
    .out_last_of_message (out_last_of_message)
  );

endmodule
